/* rtl/ltm_pkg.sv */
// Shared types, constants and the log2 fraction table generator for the
// logarithmic tone mapper. No dependencies.
package ltm_pkg;

    localparam int SAMPLE_W            = 32;
    localparam int PIX_W               = 8;
    localparam int LOG_TABLE_BITS_DEF  = 8;
    localparam int SAMPLE_FRAC_BITS_DEF = 16;

    // Configuration register widths.
    localparam int LOG_W       = 22;
    localparam int GAMMA_W     = 16;
    localparam int INV_RANGE_W = 24;
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_IDX_W   = 2;

    // Datapath widths; the log values up to the product are signed with 16 fraction bits.
    localparam int POS_W  = 5;
    localparam int FRAC_W = 16;
    localparam int L_W    = 23;
    localparam int D_W    = 24;
    localparam int P_W    = D_W + GAMMA_W + 1;
    localparam int G_W    = P_W - 14;
    localparam int T_W    = G_W + 1;
    localparam int U_W    = T_W + INV_RANGE_W + 1;
    localparam int R_W    = 64;
    localparam int Q_W    = R_W - 40;

    localparam logic [CFG_DATA_W-1:0] GAMMA_RESET     = CFG_DATA_W'(16384);
    localparam logic [CFG_DATA_W-1:0] INV_RANGE_RESET = CFG_DATA_W'(2097152);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOG_MAX,
        REG_LOG_MULT,
        REG_GAMMA_GAIN,
        REG_INV_RANGE
    } ltm_reg_idx_t;

    // Load enables of the five pipeline stages.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } ltm_stage_en_t;

    // Fraction of log2(1 + idx / 2^tab_bits) in 16 bits, by repeated squaring.
    // Only evaluated at elaboration to fill the constant table.
    function automatic logic [FRAC_W-1:0] frac_log(input int unsigned idx,
                                                   input int unsigned tab_bits);
        longint unsigned m;
        logic [FRAC_W-1:0] res;
        m   = (64'd1 << 30) + (64'(idx) << (30 - tab_bits));
        res = '0;
        for (int k = 0; k < FRAC_W; k++)
        begin
            m   = (m * m) >> 30;
            res = {res[FRAC_W-2:0], 1'b0};
            if (m >= (64'd1 << 31))
            begin
                res[0] = 1'b1;
                m      = m >> 1;
            end
        end
        return res;
    endfunction

endpackage

/* rtl/ltm_ifs.sv */
// Valid/ready channel interfaces for the tone mapper: one for input pixels,
// one for mapped pixels. Depends on ltm_pkg.
interface ltm_in_if;
    logic                          valid;
    logic                          ready;
    logic [ltm_pkg::SAMPLE_W-1:0]  blue_sample;
    logic [ltm_pkg::SAMPLE_W-1:0]  green_sample;
    logic [ltm_pkg::SAMPLE_W-1:0]  red_sample;

    modport source (output valid, blue_sample, green_sample, red_sample, input ready);
    modport sink   (input valid, blue_sample, green_sample, red_sample, output ready);
endinterface

interface ltm_out_if;
    logic                       valid;
    logic                       ready;
    logic [ltm_pkg::PIX_W-1:0]  blue_out;
    logic [ltm_pkg::PIX_W-1:0]  green_out;
    logic [ltm_pkg::PIX_W-1:0]  red_out;

    modport source (output valid, blue_out, green_out, red_out, input ready);
    modport sink   (input valid, blue_out, green_out, red_out, output ready);
endinterface

/* rtl/ltm_log2.sv */
// Stages one and two of one channel: leading-one detect, normalize and
// fraction table lookup giving log2 of the sample. Depends on ltm_pkg.
module ltm_log2 #(
    parameter int LOG_TABLE_BITS   = ltm_pkg::LOG_TABLE_BITS_DEF,
    parameter int SAMPLE_FRAC_BITS = ltm_pkg::SAMPLE_FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  ltm_pkg::ltm_stage_en_t              en,
    input  logic [ltm_pkg::SAMPLE_W-1:0]        sample,
    output logic signed [ltm_pkg::L_W-1:0]      log_val,
    output logic                                zero
);
    import ltm_pkg::*;

    localparam int TAB_SIZE = 1 << LOG_TABLE_BITS;
    localparam logic signed [L_W-FRAC_W-1:0] FRAC_OFS = (L_W-FRAC_W)'(SAMPLE_FRAC_BITS);

    logic [FRAC_W-1:0] log_tab [TAB_SIZE];

    for (genvar i = 0; i < TAB_SIZE; i++)
    begin : g_tab
        assign log_tab[i] = frac_log(i, LOG_TABLE_BITS);
    end

    logic [POS_W-1:0]    pos;
    logic [SAMPLE_W-1:0] s1_x_reg;
    logic [POS_W-1:0]    s1_pos_reg;
    logic                s1_zero_reg;

    always_comb
    begin
        pos = '0;
        for (int i = 0; i < SAMPLE_W; i++)
        begin
            if (sample[i])
                pos = POS_W'(i);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            s1_x_reg    <= sample;
            s1_pos_reg  <= pos;
            s1_zero_reg <= (sample == '0);
        end
    end

    // Shift the leading one to the top; the table index sits right below it.
    logic [SAMPLE_W-1:0]               norm;
    logic [LOG_TABLE_BITS-1:0]         idx;
    logic signed [L_W-FRAC_W-1:0]      int_part;
    logic signed [L_W-1:0]             s2_log_reg;
    logic                              s2_zero_reg;

    always_comb
    begin
        norm     = s1_x_reg << (POS_W'(SAMPLE_W - 1) - s1_pos_reg);
        idx      = norm[SAMPLE_W-2 -: LOG_TABLE_BITS];
        int_part = $signed({{(L_W-FRAC_W-POS_W){1'b0}}, s1_pos_reg}) - FRAC_OFS;
    end

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            s2_log_reg  <= $signed({int_part, log_tab[idx]});
            s2_zero_reg <= s1_zero_reg;
        end
    end

    assign log_val = s2_log_reg;
    assign zero    = s2_zero_reg;

endmodule

/* rtl/ltm_scale.sv */
// Stages three to five of one channel: gamma gain, exposure offset, range
// scaling, rounding and saturation to 8 bits. Depends on ltm_pkg.
module ltm_scale (
    input  logic                                    clk,
    input  ltm_pkg::ltm_stage_en_t                  en,
    input  logic signed [ltm_pkg::L_W-1:0]          log_val,
    input  logic                                    zero,
    input  logic signed [ltm_pkg::LOG_W-1:0]        log_max,
    input  logic signed [ltm_pkg::LOG_W-1:0]        log_mult,
    input  logic [ltm_pkg::GAMMA_W-1:0]             gamma_gain,
    input  logic [ltm_pkg::INV_RANGE_W-1:0]         inv_range,
    output logic [ltm_pkg::PIX_W-1:0]               result
);
    import ltm_pkg::*;

    localparam logic signed [R_W-1:0] ROUND_K = (R_W'(255) << 40) + (R_W'(1) << 39);
    localparam logic signed [Q_W-1:0] SAT_MAX = Q_W'(255);

    // Stage three: difference to the upper bound times gamma, floor to 16 fractions.
    logic signed [D_W-1:0]  diff;
    logic signed [P_W-1:0]  prod;
    logic signed [G_W-1:0]  s3_g_reg;
    logic                   s3_zero_reg;

    always_comb
    begin
        diff = D_W'(log_val) - D_W'(log_max);
        prod = $signed({1'b0, gamma_gain}) * diff;
    end

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            s3_g_reg    <= prod[P_W-1:14];
            s3_zero_reg <= zero;
        end
    end

    // Stage four: add the exposure offset and scale by the inverse range.
    logic signed [T_W-1:0]  t_sum;
    logic signed [U_W-1:0]  u_prod;
    logic signed [U_W-1:0]  s4_u_reg;
    logic                   s4_zero_reg;

    always_comb
    begin
        t_sum  = T_W'(s3_g_reg) + T_W'(log_mult);
        u_prod = t_sum * $signed({1'b0, inv_range});
    end

    always_ff @(posedge clk)
    begin
        if (en.s4)
        begin
            s4_u_reg    <= u_prod;
            s4_zero_reg <= s3_zero_reg;
        end
    end

    // Stage five: (u + 1) * 255 with round half up, then clamp to 0..255.
    logic signed [R_W-1:0]  u_ext;
    logic signed [R_W-1:0]  r_sum;
    logic signed [Q_W-1:0]  q_val;
    logic [PIX_W-1:0]       sat;
    logic [PIX_W-1:0]       out_reg;

    always_comb
    begin
        u_ext = R_W'(s4_u_reg);
        r_sum = (u_ext <<< 8) - u_ext + ROUND_K;
        q_val = r_sum[R_W-1:40];
        if (q_val < 0)
            sat = '0;
        else if (q_val > SAT_MAX)
            sat = '1;
        else
            sat = q_val[PIX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en.s5)
            out_reg <= s4_zero_reg ? '0 : sat;
    end

    assign result = out_reg;

endmodule

/* rtl/log_tone_map_pixel_to_8bit_top.sv */
// Top level of the logarithmic tone mapper: configuration registers, the
// pipeline valid/stall control and three channel datapaths.
// Depends on ltm_pkg, ltm_ifs, ltm_log2 and ltm_scale.
//
// Maps each pixel of three unsigned linear samples to three 8-bit values: log2
// of each sample (leading-one detect plus a fraction table of 2^LOG_TABLE_BITS
// entries) is shifted by log_max, scaled by gamma_gain, offset by log_mult,
// scaled by inv_range, then mapped through (x + 1) * 255 with round half up
// and clamped to 0..255. A zero sample gives 0. The datapath is five register
// stages deep (detect, table, gamma multiply, range multiply, round and
// clamp); a word accepted on sample_ch passes through them in order before it
// is offered on result_ch. One word is accepted every cycle while the output
// is not stalled. Each stage holds its word while the stage after it is full
// and stalled, so bubbles are squeezed out and sample_ch keeps accepting while
// a finished word waits on result_ch, until all five stages hold words. Write
// the registers through cfg_we, cfg_index and cfg_wdata only while no word is
// in flight; the block itself does not enforce this.
module log_tone_map_pixel_to_8bit_top #(
    parameter int LOG_TABLE_BITS   = ltm_pkg::LOG_TABLE_BITS_DEF,
    parameter int SAMPLE_FRAC_BITS = ltm_pkg::SAMPLE_FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ltm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ltm_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    ltm_in_if.sink                              sample_ch,
    ltm_out_if.source                           result_ch
);
    import ltm_pkg::*;

    localparam int NSTG = 5;
    localparam int NCH  = 3;

    // Configuration registers.
    logic signed [LOG_W-1:0]  log_max_reg;
    logic signed [LOG_W-1:0]  log_mult_reg;
    logic [GAMMA_W-1:0]       gamma_gain_reg;
    logic [INV_RANGE_W-1:0]   inv_range_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log_max_reg    <= '0;
            log_mult_reg   <= '0;
            gamma_gain_reg <= GAMMA_RESET[GAMMA_W-1:0];
            inv_range_reg  <= INV_RANGE_RESET[INV_RANGE_W-1:0];
        end
        else if (cfg_we)
        begin
            case (ltm_reg_idx_t'(cfg_index))
                REG_LOG_MAX:    log_max_reg    <= cfg_wdata[LOG_W-1:0];
                REG_LOG_MULT:   log_mult_reg   <= cfg_wdata[LOG_W-1:0];
                REG_GAMMA_GAIN: gamma_gain_reg <= cfg_wdata[GAMMA_W-1:0];
                REG_INV_RANGE:  inv_range_reg  <= cfg_wdata[INV_RANGE_W-1:0];
                default: ;
            endcase
        end
    end

    // A stage loads when it is empty or when the stage after it loads too.
    logic [NSTG-1:0] valid_reg;
    logic [NSTG-1:0] adv;
    ltm_stage_en_t   stage_en;

    always_comb
    begin
        adv[NSTG-1] = !valid_reg[NSTG-1] || result_ch.ready;
        for (int k = NSTG - 2; k >= 0; k--)
            adv[k] = !valid_reg[k] || adv[k+1];
    end

    assign stage_en = '{s1: adv[0], s2: adv[1], s3: adv[2], s4: adv[3], s5: adv[4]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[0])
                valid_reg[0] <= sample_ch.valid;
            for (int k = 1; k < NSTG; k++)
            begin
                if (adv[k])
                    valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    assign sample_ch.ready = adv[0];
    assign result_ch.valid = valid_reg[NSTG-1];

    // Per-channel datapaths: index 0 blue, 1 green, 2 red.
    logic [SAMPLE_W-1:0]     smp     [NCH];
    logic signed [L_W-1:0]   log_val [NCH];
    logic                    zero    [NCH];
    logic [PIX_W-1:0]        pix     [NCH];

    assign smp[0] = sample_ch.blue_sample;
    assign smp[1] = sample_ch.green_sample;
    assign smp[2] = sample_ch.red_sample;

    for (genvar c = 0; c < NCH; c++)
    begin : g_ch
        ltm_log2 #(
            .LOG_TABLE_BITS   (LOG_TABLE_BITS),
            .SAMPLE_FRAC_BITS (SAMPLE_FRAC_BITS)
        ) u_log2 (
            .clk     (clk),
            .en      (stage_en),
            .sample  (smp[c]),
            .log_val (log_val[c]),
            .zero    (zero[c])
        );

        ltm_scale u_scale (
            .clk        (clk),
            .en         (stage_en),
            .log_val    (log_val[c]),
            .zero       (zero[c]),
            .log_max    (log_max_reg),
            .log_mult   (log_mult_reg),
            .gamma_gain (gamma_gain_reg),
            .inv_range  (inv_range_reg),
            .result     (pix[c])
        );
    end

    assign result_ch.blue_out  = pix[0];
    assign result_ch.green_out = pix[1];
    assign result_ch.red_out   = pix[2];

endmodule

/* rtl/ltm_chk.sv */
// Port-level checker for the tone mapper and its bind to the top level.
// Depends on ltm_pkg and log_tone_map_pixel_to_8bit_top.
module ltm_chk (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic [ltm_pkg::SAMPLE_W-1:0]    blue_sample,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [ltm_pkg::PIX_W-1:0]       blue_out
);
    import ltm_pkg::*;

    logic in_acc;
    assign in_acc = in_valid && in_ready;

    // The first cycle after reset shows no result word.
    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !out_valid)
        else $error("result word valid right after reset");

    // With the output register empty the whole pipeline can move.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled while output is empty");

    // Five stages: an unstalled word reaches the output on time.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc ##1 out_ready ##1 out_ready ##1 out_ready ##1 out_ready) |=> out_valid)
        else $error("result word late");

    // A zero blue sample maps to zero.
    a_zero_maps_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && blue_sample == '0 ##1 out_ready ##1 out_ready ##1 out_ready
         ##1 out_ready) |=> (out_valid && blue_out == '0))
        else $error("zero sample did not map to zero");

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(blue_out)))
        else $error("stalled result word changed");

endmodule

bind log_tone_map_pixel_to_8bit_top ltm_chk u_ltm_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (sample_ch.valid),
    .in_ready    (sample_ch.ready),
    .blue_sample (sample_ch.blue_sample),
    .out_valid   (result_ch.valid),
    .out_ready   (result_ch.ready),
    .blue_out    (result_ch.blue_out)
);
